[sv/gprs_pkg.sv]
package gprs_pkg;

	localparam int ERR_W = 16;
	localparam int MS_W = 16;
	localparam int HIST_DEPTH_DEF = 10;
	localparam int SWITCH_VOTES = 3;

	typedef enum logic [2:0] {
		CFG_RA_HYSTERESIS = 3'd0,
		CFG_RA_AGGRESSION = 3'd1,
		CFG_RA_MS_PER_PX  = 3'd2,
		CFG_DEC_MS_PER_PX = 3'd3,
		CFG_MAX_RA_MS     = 3'd4,
		CFG_MAX_DEC_MS    = 3'd5,
		CFG_MIN_MOTION    = 3'd6,
		CFG_DEC_MODE      = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		DEC_OFF    = 2'd0,
		DEC_BOTH   = 2'd1,
		DEC_N_ONLY = 2'd2,
		DEC_S_ONLY = 2'd3
	} dec_mode_t;

	localparam logic [8:0]  RST_RA_HYSTERESIS = 9'd26;
	localparam logic [9:0]  RST_RA_AGGRESSION = 10'd256;
	localparam logic [15:0] RST_RA_MS_PER_PX  = 16'd4096;
	localparam logic [15:0] RST_DEC_MS_PER_PX = 16'd4096;
	localparam logic [15:0] RST_MAX_RA_MS     = 16'd1000;
	localparam logic [15:0] RST_MAX_DEC_MS    = 16'd1000;
	localparam logic [14:0] RST_MIN_MOTION    = 15'd38;

	localparam logic signed [1:0] SIDE_NONE  = 2'sb00;
	localparam logic signed [1:0] SIDE_PLUS  = 2'sb01;
	localparam logic signed [1:0] SIDE_MINUS = 2'sb11;

	typedef struct packed {
		logic signed [ERR_W-1:0] filt;
		logic [ERR_W:0]          mag;
		logic [22:0]             raw;
	} ra_calc_t;

endpackage

[sv/gprs_frame_if.sv]
interface gprs_frame_if;
	logic                                valid;
	logic                                ready;
	logic signed [gprs_pkg::ERR_W-1:0]   ra_error;
	logic signed [gprs_pkg::ERR_W-1:0]   dec_error;

	modport source(output valid, ra_error, dec_error, input ready);
	modport sink(input valid, ra_error, dec_error, output ready);
endinterface

[sv/gprs_pulse_if.sv]
interface gprs_pulse_if;
	logic                          valid;
	logic                          ready;
	logic [gprs_pkg::MS_W-1:0]     ra_pulse_ms;
	logic                          ra_east;
	logic [gprs_pkg::MS_W-1:0]     dec_pulse_ms;
	logic                          dec_to_south;
	logic signed [1:0]             dec_side;

	modport source(output valid, ra_pulse_ms, ra_east, dec_pulse_ms, dec_to_south, dec_side,
		input ready);
	modport sink(input valid, ra_pulse_ms, ra_east, dec_pulse_ms, dec_to_south, dec_side,
		output ready);
endinterface

[sv/gprs_cell.sv]
module gprs_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              shift,
	input  logic signed [gprs_pkg::ERR_W-1:0] d,
	output logic signed [gprs_pkg::ERR_W-1:0] q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (shift) begin
			q <= d;
		end
	end

endmodule

[sv/gprs_ra.sv]
module gprs_ra (
	input  logic                              clk,
	input  logic signed [gprs_pkg::ERR_W-1:0] ra,
	input  logic signed [gprs_pkg::ERR_W-1:0] last,
	input  logic [8:0]                        hyst,
	input  logic [15:0]                       ms_per_px,
	input  logic [9:0]                        aggr,
	output gprs_pkg::ra_calc_t                calc
);

	logic [8:0]                        keep;
	logic signed [25:0]                p_new_s1;
	logic signed [25:0]                p_old_s1;
	logic signed [26:0]                sum;
	logic signed [26:0]                sum_b;
	logic signed [gprs_pkg::ERR_W-1:0] filt_s2;
	logic [gprs_pkg::ERR_W:0]          mag_f;
	logic signed [gprs_pkg::ERR_W-1:0] filt_s3;
	logic [gprs_pkg::ERR_W:0]          mag_s3;
	logic [32:0]                       m1_s3;
	logic signed [gprs_pkg::ERR_W-1:0] filt_s4;
	logic [gprs_pkg::ERR_W:0]          mag_s4;
	logic [42:0]                       m2_s4;

	assign keep = 9'd256 - hyst;
	assign sum = 27'(p_new_s1) + 27'(p_old_s1);
	// bias negative sums so the shift truncates toward zero
	assign sum_b = sum + (sum[26] ? 27'sd255 : 27'sd0);
	assign mag_f = filt_s2[gprs_pkg::ERR_W-1] ?
		17'(~{filt_s2[gprs_pkg::ERR_W-1], filt_s2} + 17'd1) : {1'b0, filt_s2};

	always_ff @(posedge clk) begin
		p_new_s1 <= $signed({1'b0, keep}) * ra;
		p_old_s1 <= $signed({1'b0, hyst}) * last;
		filt_s2  <= 16'(sum_b >>> 8);
		filt_s3  <= filt_s2;
		mag_s3   <= mag_f;
		m1_s3    <= 33'(mag_f) * 33'(ms_per_px);
		filt_s4  <= filt_s3;
		mag_s4   <= mag_s3;
		m2_s4    <= 43'(m1_s3) * 43'(aggr);
	end

	assign calc.filt = filt_s4;
	assign calc.mag  = mag_s4;
	assign calc.raw  = m2_s4[42:20];

endmodule

[sv/guide_pulse_resist_switch_unit.sv]
// Guide pulse unit: one frame item (RA and Dec error, Q8.8 pixels) yields one pulse item.
// Acceptance pushes the Dec error into the history chain unless Dec mode is off; a scan
// then rotates the chain once past the sign vote counter at its oldest cell, and a
// decision state loads the result register once it is free. The RA multiplier pipeline
// runs alongside the rotation. A new frame is taken in the cycle after the result is
// loaded, while that result may still wait for the sink. The history resets to zero in
// one step; no clearing pass is needed. The user must write configuration through
// cfg_we/cfg_index/cfg_data while the unit is idle; the unit does not enforce this.
module guide_pulse_resist_switch_unit #(
	parameter int HISTORY_DEPTH = gprs_pkg::HIST_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	gprs_frame_if.sink          frame,
	gprs_pulse_if.source        pulse,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	localparam int CNT_W = $clog2(HISTORY_DEPTH);
	localparam int VW = $clog2(HISTORY_DEPTH + 1) + 1;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_DECIDE = 3'b100
	} state_t;

	state_t                            state_q;
	logic [CNT_W-1:0]                  cnt_q;
	logic signed [VW-1:0]              vote_q;
	logic signed [1:0]                 side_q;
	logic signed [gprs_pkg::ERR_W-1:0] last_q;
	logic signed [gprs_pkg::ERR_W-1:0] ra_q;
	logic signed [gprs_pkg::ERR_W-1:0] dec_q;
	logic [32:0]                       dprod_s1;

	logic [8:0]                        hyst_q;
	logic [9:0]                        aggr_q;
	logic [15:0]                       ra_ms_q;
	logic [15:0]                       dec_ms_q;
	logic [15:0]                       max_ra_q;
	logic [15:0]                       max_dec_q;
	logic [14:0]                       min_motion_q;
	gprs_pkg::dec_mode_t               dec_mode_q;

	logic                              accept;
	logic                              push;
	logic                              shift;
	logic                              load;
	logic [8:0]                        hyst_sat;
	gprs_pkg::ra_calc_t                ra_calc;
	logic signed [gprs_pkg::ERR_W-1:0] hist [HISTORY_DEPTH];
	logic signed [gprs_pkg::ERR_W-1:0] hist_d [HISTORY_DEPTH];
	logic [gprs_pkg::ERR_W:0]          mag_head;
	logic signed [VW-1:0]              contrib;
	logic [gprs_pkg::ERR_W:0]          mag_dec;
	logic [gprs_pkg::ERR_W:0]          mm;
	logic signed [17:0]                old3;
	logic signed [17:0]                new3;
	logic [17:0]                       old3_mag;
	logic [17:0]                       new3_mag;
	logic [VW-1:0]                     vote_mag;
	logic signed [1:0]                 vote_sgn;
	logic signed [1:0]                 dec_sgn;
	logic [20:0]                       dec_raw;
	logic [15:0]                       ra_pulse;
	logic                              ra_east;
	logic [15:0]                       dec_pulse;
	logic                              dec_to_south;
	logic signed [1:0]                 side_n;
	logic                              allow;
	logic                              autom;

	assign frame.ready = (state_q == ST_IDLE);
	assign accept = frame.valid && frame.ready;
	assign push = accept && (dec_mode_q != gprs_pkg::DEC_OFF);
	assign shift = push || (state_q == ST_SCAN);
	assign load = (state_q == ST_DECIDE) && (!pulse.valid || pulse.ready);
	assign hyst_sat = (hyst_q > 9'd256) ? 9'd256 : hyst_q;

	// history chain: cell 0 oldest, new entries and rotation enter at the far end
	for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
		if (i == HISTORY_DEPTH - 1) begin : g_tail
			assign hist_d[i] = push ? frame.dec_error : hist[0];
		end else begin : g_body
			assign hist_d[i] = hist[i+1];
		end
		gprs_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.d      (hist_d[i]),
			.q      (hist[i])
		);
	end

	gprs_ra u_ra (
		.clk       (clk),
		.ra        (ra_q),
		.last      (last_q),
		.hyst      (hyst_sat),
		.ms_per_px (ra_ms_q),
		.aggr      (aggr_q),
		.calc      (ra_calc)
	);

	assign mm = 17'(min_motion_q);
	assign mag_head = hist[0][gprs_pkg::ERR_W-1] ?
		17'(~{hist[0][gprs_pkg::ERR_W-1], hist[0]} + 17'd1) : {1'b0, hist[0]};
	assign contrib = (mag_head > mm) ?
		(hist[0][gprs_pkg::ERR_W-1] ? -VW'(1) : VW'(1)) : '0;
	assign mag_dec = dec_q[gprs_pkg::ERR_W-1] ?
		17'(~{dec_q[gprs_pkg::ERR_W-1], dec_q} + 17'd1) : {1'b0, dec_q};

	assign old3 = 18'(hist[0]) + 18'(hist[1]) + 18'(hist[2]);
	assign new3 = 18'(hist[HISTORY_DEPTH-1]) + 18'(hist[HISTORY_DEPTH-2]) +
		18'(hist[HISTORY_DEPTH-3]);
	assign old3_mag = old3[17] ? 18'(-old3) : 18'(old3);
	assign new3_mag = new3[17] ? 18'(-new3) : 18'(new3);
	assign vote_mag = vote_q[VW-1] ? VW'(-vote_q) : VW'(vote_q);
	assign vote_sgn = (vote_q == '0) ? gprs_pkg::SIDE_NONE :
		(vote_q[VW-1] ? gprs_pkg::SIDE_MINUS : gprs_pkg::SIDE_PLUS);
	assign dec_sgn = (dec_q == '0) ? gprs_pkg::SIDE_NONE :
		(dec_q[gprs_pkg::ERR_W-1] ? gprs_pkg::SIDE_MINUS : gprs_pkg::SIDE_PLUS);
	assign dec_raw = dprod_s1[32:12];

	always_comb begin
		ra_pulse = (ra_calc.raw > 23'(max_ra_q)) ? max_ra_q : ra_calc.raw[15:0];
		if (ra_calc.mag <= mm) begin
			ra_pulse = '0;
		end
		ra_east = (ra_pulse != '0) && !ra_calc.filt[gprs_pkg::ERR_W-1];
	end

	always_comb begin
		autom = (dec_mode_q == gprs_pkg::DEC_BOTH);
		allow = (mag_dec >= mm);
		side_n = side_q;
		dec_pulse = '0;
		if (autom && allow && (side_q != vote_sgn)) begin
			allow = 1'b0;
			if ((vote_mag >= VW'(gprs_pkg::SWITCH_VOTES)) && (old3_mag < new3_mag)) begin
				side_n = vote_sgn;
				allow = 1'b1;
			end
		end
		if (allow && autom && (side_n != dec_sgn)) begin
			allow = 1'b0;
		end
		if (allow && (mag_dec > mm)) begin
			dec_pulse = (dec_raw > 21'(max_dec_q)) ? max_dec_q : dec_raw[15:0];
			if (!dec_q[gprs_pkg::ERR_W-1]) begin
				if (!(dec_mode_q == gprs_pkg::DEC_BOTH || dec_mode_q == gprs_pkg::DEC_S_ONLY)) begin
					dec_pulse = '0;
				end
			end else begin
				if (!(dec_mode_q == gprs_pkg::DEC_BOTH || dec_mode_q == gprs_pkg::DEC_N_ONLY)) begin
					dec_pulse = '0;
				end
			end
		end
		if (dec_mode_q == gprs_pkg::DEC_OFF) begin
			side_n = side_q;
			dec_pulse = '0;
		end
		dec_to_south = (dec_pulse != '0) && !dec_q[gprs_pkg::ERR_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			vote_q  <= '0;
			side_q  <= gprs_pkg::SIDE_NONE;
			last_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
						vote_q  <= '0;
					end
				end
				ST_SCAN: begin
					vote_q <= vote_q + contrib;
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(HISTORY_DEPTH - 1)) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (load) begin
						side_q  <= side_n;
						last_q  <= ra_calc.filt;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ra_q  <= frame.ra_error;
			dec_q <= frame.dec_error;
		end
		dprod_s1 <= 33'(mag_dec) * 33'(dec_ms_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hyst_q       <= gprs_pkg::RST_RA_HYSTERESIS;
			aggr_q       <= gprs_pkg::RST_RA_AGGRESSION;
			ra_ms_q      <= gprs_pkg::RST_RA_MS_PER_PX;
			dec_ms_q     <= gprs_pkg::RST_DEC_MS_PER_PX;
			max_ra_q     <= gprs_pkg::RST_MAX_RA_MS;
			max_dec_q    <= gprs_pkg::RST_MAX_DEC_MS;
			min_motion_q <= gprs_pkg::RST_MIN_MOTION;
			dec_mode_q   <= gprs_pkg::DEC_BOTH;
		end else if (cfg_we) begin
			unique case (gprs_pkg::cfg_idx_t'(cfg_index))
				gprs_pkg::CFG_RA_HYSTERESIS: hyst_q       <= cfg_data[8:0];
				gprs_pkg::CFG_RA_AGGRESSION: aggr_q       <= cfg_data[9:0];
				gprs_pkg::CFG_RA_MS_PER_PX:  ra_ms_q      <= cfg_data;
				gprs_pkg::CFG_DEC_MS_PER_PX: dec_ms_q     <= cfg_data;
				gprs_pkg::CFG_MAX_RA_MS:     max_ra_q     <= cfg_data;
				gprs_pkg::CFG_MAX_DEC_MS:    max_dec_q    <= cfg_data;
				gprs_pkg::CFG_MIN_MOTION:    min_motion_q <= cfg_data[14:0];
				gprs_pkg::CFG_DEC_MODE:      dec_mode_q   <= gprs_pkg::dec_mode_t'(cfg_data[1:0]);
				default: ;
			endcase
		end
	end

	// result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse.valid <= 1'b0;
		end else if (load) begin
			pulse.valid <= 1'b1;
		end else if (pulse.ready) begin
			pulse.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pulse.ra_pulse_ms  <= ra_pulse;
			pulse.ra_east      <= ra_east;
			pulse.dec_pulse_ms <= dec_pulse;
			pulse.dec_to_south <= dec_to_south;
			pulse.dec_side     <= side_n;
		end
	end

endmodule

[sv/gprs_check.sv]
module gprs_check (
	input logic        clk,
	input logic        arst_n,
	input logic        frame_valid,
	input logic        frame_ready,
	input logic        pulse_valid,
	input logic        pulse_ready,
	input logic [15:0] ra_pulse_ms,
	input logic        ra_east,
	input logic [15:0] dec_pulse_ms,
	input logic        dec_to_south,
	input logic [1:0]  dec_side
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pulse_valid && !pulse_ready |=> pulse_valid && $stable(ra_pulse_ms) &&
		$stable(ra_east) && $stable(dec_pulse_ms) && $stable(dec_to_south) && $stable(dec_side))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && frame_ready |=> !frame_ready)
		else $error("item accepted while previous one in work");

	a_side_code: assert property (@(posedge clk) disable iff (!arst_n)
		pulse_valid |-> dec_side != 2'b10)
		else $error("invalid backlash side");

	a_east_needs_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		pulse_valid && ra_east |-> ra_pulse_ms != 16'd0)
		else $error("east direction without RA pulse");

	a_south_needs_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		pulse_valid && dec_to_south |-> dec_pulse_ms != 16'd0)
		else $error("south direction without Dec pulse");

endmodule

bind guide_pulse_resist_switch_unit gprs_check u_gprs_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.frame_valid  (frame.valid),
	.frame_ready  (frame.ready),
	.pulse_valid  (pulse.valid),
	.pulse_ready  (pulse.ready),
	.ra_pulse_ms  (pulse.ra_pulse_ms),
	.ra_east      (pulse.ra_east),
	.dec_pulse_ms (pulse.dec_pulse_ms),
	.dec_to_south (pulse.dec_to_south),
	.dec_side     (pulse.dec_side)
);
